// ===== hw/rtl/alt_pkg.sv =====
package alt_pkg;

  localparam int unsigned MaxLineLengthDef = 256;

  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = 2;
  localparam int unsigned ResCntW  = 3;

  localparam logic [2:0] KIND_LABEL = 3'd0;
  localparam logic [2:0] KIND_INSTR = 3'd1;
  localparam logic [2:0] KIND_PARAM = 3'd2;
  localparam logic [2:0] KIND_OK    = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_TWO_LABELS = 2'd1;
  localparam logic [1:0] ERR_BAD_CHAR   = 2'd2;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_BLANK  = 8'h20;

  typedef struct packed {
    logic [2:0] token_kind;
    logic       is_directive;
    logic [7:0] start_pos;
    logic [8:0] end_pos;
    logic [7:0] param_index;
    logic [1:0] error_code;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    logic       rd;
  } fifo_ctl_t;

endpackage

// ===== hw/rtl/alt_if.sv =====
interface alt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       has_char;
  logic       end_of_line;

  modport source (output valid, ch, has_char, end_of_line, input ready);
  modport sink   (input valid, ch, has_char, end_of_line, output ready);
endinterface

interface alt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic       is_directive;
  logic [7:0] start_pos;
  logic [8:0] end_pos;
  logic [7:0] param_index;
  logic [1:0] error_code;
  logic       last;

  modport source (output valid, token_kind, is_directive, start_pos, end_pos, param_index,
                  error_code, last, input ready);
  modport sink   (input valid, token_kind, is_directive, start_pos, end_pos, param_index,
                  error_code, last, output ready);
endinterface

// ===== hw/rtl/alt_res_fifo.sv =====
module alt_res_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  alt_pkg::fifo_ctl_t ctl_i,
  input  alt_pkg::res_t     wr0_i,
  input  alt_pkg::res_t     wr1_i,
  output alt_pkg::res_t     rd_data_o,
  output logic              valid_o,
  output logic              room_o
);

  alt_pkg::res_t                 mem_q [alt_pkg::ResDepth];
  logic [alt_pkg::ResPtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [alt_pkg::ResCntW-1:0]   cnt_q, cnt_d;
  logic [alt_pkg::ResPtrW-1:0]   wptr_p1;

  assign wptr_p1 = wptr_q + alt_pkg::ResPtrW'(1);

  always_comb begin
    wptr_d = wptr_q + alt_pkg::ResPtrW'(ctl_i.count);
    rptr_d = rptr_q + alt_pkg::ResPtrW'(ctl_i.rd);
    cnt_d  = cnt_q + alt_pkg::ResCntW'(ctl_i.count) - alt_pkg::ResCntW'(ctl_i.rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.count != 2'd0) begin
      mem_q[wptr_q] <= wr0_i;
    end
    if (ctl_i.count == 2'd2) begin
      mem_q[wptr_p1] <= wr1_i;
    end
  end

  assign rd_data_o = mem_q[rptr_q];
  assign valid_o   = (cnt_q != '0);
  // room for a full pair of results
  assign room_o    = (cnt_q <= alt_pkg::ResCntW'(alt_pkg::ResDepth - 2));

endmodule

// ===== hw/rtl/assembler_line_tokenizer.sv =====
// Channel | Dir | Words                                   | Per accepted word
// in_i    | in  | ch, has_char, end_of_line               | one character or line end
// out_o   | out | token_kind .. error_code, last          | 0 to 2 token records
//
// A character is consumed and its records computed in the same cycle. Records sit in
// a four-entry result queue and leave one per cycle while out_o is ready. in_i.ready
// is high, and input flows at one word per cycle, while the queue has room for two
// records. rst_ni clears the line state and empties the queue.
module assembler_line_tokenizer #(
  parameter int unsigned MAX_LINE_LENGTH = alt_pkg::MaxLineLengthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  alt_in_if.sink    in_i,
  alt_out_if.source out_o
);

  localparam int unsigned PosW = $clog2(MAX_LINE_LENGTH + 1);

  localparam logic [2:0] PH_NAME       = 3'd0;
  localparam logic [2:0] PH_SKIP_PARAM = 3'd1;
  localparam logic [2:0] PH_IN_PARAM   = 3'd2;
  localparam logic [2:0] PH_COMMENT    = 3'd3;
  localparam logic [2:0] PH_DEAD       = 3'd4;

  logic [2:0]      phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            label_q, label_d;
  logic [7:0]      tok_beg_q, tok_beg_d;
  logic [PosW-1:0] lne_q, lne_d;
  logic            quote_q, quote_d;
  logic            bslash_q, bslash_d;
  logic [7:0]      pcnt_q, pcnt_d;
  logic            nonempty_q, nonempty_d;
  logic            dir_q, dir_d;

  alt_pkg::res_t     res0, res1, rd_data;
  alt_pkg::fifo_ctl_t fctl;
  logic              accept, room, fifo_valid;

  function automatic logic is_space(input logic [7:0] c);
    return (c == alt_pkg::CH_BLANK) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || c == alt_pkg::CH_USCORE || c == alt_pkg::CH_DOT;
  endfunction

  function automatic logic [7:0] clamp_start(input logic [PosW-1:0] p);
    logic [PosW+8:0] pe;
    pe = {9'd0, p};
    return (pe > (PosW+9)'(255)) ? 8'd255 : pe[7:0];
  endfunction

  function automatic logic [8:0] clamp_end(input logic [PosW-1:0] p);
    logic [PosW+8:0] pe;
    pe = {9'd0, p};
    return (pe > (PosW+9)'(511)) ? 9'd511 : pe[8:0];
  endfunction

  function automatic logic [PosW-1:0] next_pos(input logic [PosW-1:0] p);
    return (p >= PosW'(MAX_LINE_LENGTH)) ? PosW'(MAX_LINE_LENGTH) : p + PosW'(1);
  endfunction

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = room;

  always_comb begin
    logic [1:0]      n;
    logic [7:0]      c;
    logic [PosW-1:0] p;
    alt_pkg::res_t   rec;
    logic            put;

    phase_d    = phase_q;
    pos_d      = pos_q;
    label_d    = label_q;
    tok_beg_d  = tok_beg_q;
    lne_d      = lne_q;
    quote_d    = quote_q;
    bslash_d   = bslash_q;
    pcnt_d     = pcnt_q;
    nonempty_d = nonempty_q;
    dir_d      = dir_q;
    res0       = '0;
    res1       = '0;
    rec        = '0;
    put        = 1'b0;
    n          = 2'd0;
    c          = in_i.ch;
    p          = pos_q;

    if (accept && in_i.has_char) begin
      if (phase_q == PH_NAME) begin
        rec = '0;
        put = 1'b0;
        if (is_name_char(c)) begin
          if (!nonempty_q) begin
            tok_beg_d  = clamp_start(p);
            nonempty_d = 1'b1;
            dir_d      = (c == alt_pkg::CH_DOT);
          end
          lne_d = next_pos(p);
        end else if (c == alt_pkg::CH_COLON) begin
          if (label_q) begin
            rec.token_kind = alt_pkg::KIND_ERROR;
            rec.start_pos  = clamp_start(p);
            rec.end_pos    = clamp_end(p);
            rec.error_code = alt_pkg::ERR_TWO_LABELS;
            put            = 1'b1;
            phase_d        = PH_DEAD;
          end else begin
            if (nonempty_q) begin
              rec.token_kind = alt_pkg::KIND_LABEL;
              rec.start_pos  = tok_beg_q;
              rec.end_pos    = clamp_end(lne_q);
              put            = 1'b1;
              label_d        = 1'b1;
            end
            nonempty_d = 1'b0;
            dir_d      = 1'b0;
          end
        end else if (is_space(c)) begin
          if (nonempty_q) begin
            rec.token_kind   = alt_pkg::KIND_INSTR;
            rec.is_directive = dir_q;
            rec.start_pos    = tok_beg_q;
            rec.end_pos      = clamp_end(lne_q);
            put              = 1'b1;
            nonempty_d       = 1'b0;
            dir_d            = 1'b0;
            phase_d          = PH_SKIP_PARAM;
          end
        end else if (c == alt_pkg::CH_SEMI) begin
          if (nonempty_q) begin
            rec.token_kind   = alt_pkg::KIND_INSTR;
            rec.is_directive = dir_q;
            rec.start_pos    = tok_beg_q;
            rec.end_pos      = clamp_end(lne_q);
            put              = 1'b1;
          end
          nonempty_d = 1'b0;
          dir_d      = 1'b0;
          phase_d    = PH_COMMENT;
        end else begin
          rec.token_kind = alt_pkg::KIND_ERROR;
          rec.start_pos  = clamp_start(p);
          rec.end_pos    = clamp_end(p);
          rec.error_code = alt_pkg::ERR_BAD_CHAR;
          put            = 1'b1;
          phase_d        = PH_DEAD;
        end
        if (put) begin
          res0 = rec;
          n    = 2'd1;
        end
      end else if (phase_q == PH_SKIP_PARAM || phase_q == PH_IN_PARAM) begin
        if (!(phase_q == PH_SKIP_PARAM && is_space(c))) begin
          if (phase_q == PH_SKIP_PARAM) begin
            tok_beg_d  = clamp_start(p);
            quote_d    = 1'b0;
            nonempty_d = 1'b0;
            phase_d    = PH_IN_PARAM;
          end
          if (c == alt_pkg::CH_QUOTE && !bslash_q) begin
            quote_d = ~quote_d;
          end
          if ((c == alt_pkg::CH_COMMA || c == alt_pkg::CH_SEMI) && !quote_d) begin
            if (nonempty_d) begin
              res0.token_kind  = alt_pkg::KIND_PARAM;
              res0.start_pos   = tok_beg_d;
              res0.end_pos     = clamp_end(lne_d);
              res0.param_index = pcnt_d;
              n                = 2'd1;
              if (pcnt_d != 8'd255) begin
                pcnt_d = pcnt_d + 8'd1;
              end
            end
            nonempty_d = 1'b0;
            quote_d    = 1'b0;
            phase_d    = (c == alt_pkg::CH_COMMA) ? PH_SKIP_PARAM : PH_COMMENT;
          end else if (!is_space(c)) begin
            nonempty_d = 1'b1;
            lne_d      = next_pos(p);
          end
        end
      end
      pos_d    = next_pos(p);
      bslash_d = (c == alt_pkg::CH_BSLASH);
    end

    if (accept && in_i.end_of_line) begin
      if (phase_d != PH_DEAD) begin
        rec = '0;
        put = 1'b0;
        if (phase_d == PH_NAME && nonempty_d) begin
          rec.token_kind   = alt_pkg::KIND_INSTR;
          rec.is_directive = dir_d;
          rec.start_pos    = tok_beg_d;
          rec.end_pos      = clamp_end(lne_d);
          put              = 1'b1;
        end else if (phase_d == PH_IN_PARAM && nonempty_d) begin
          rec.token_kind  = alt_pkg::KIND_PARAM;
          rec.start_pos   = tok_beg_d;
          rec.end_pos     = clamp_end(lne_d);
          rec.param_index = pcnt_d;
          put             = 1'b1;
        end
        if (put) begin
          if (n == 2'd0) begin
            res0 = rec;
          end else begin
            res1 = rec;
          end
          n = n + 2'd1;
        end
        rec            = '0;
        rec.token_kind = alt_pkg::KIND_OK;
        if (n == 2'd0) begin
          res0 = rec;
          n    = 2'd1;
        end else if (n == 2'd1) begin
          res1 = rec;
          n    = 2'd2;
        end
      end
      phase_d    = PH_NAME;
      pos_d      = '0;
      label_d    = 1'b0;
      tok_beg_d  = '0;
      lne_d      = '0;
      quote_d    = 1'b0;
      bslash_d   = 1'b0;
      pcnt_d     = '0;
      nonempty_d = 1'b0;
      dir_d      = 1'b0;
    end

    if (n == 2'd1) begin
      res0.last = 1'b1;
    end else if (n == 2'd2) begin
      res1.last = 1'b1;
    end

    fctl.count = n;
    fctl.rd    = out_o.valid && out_o.ready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_NAME;
      pos_q      <= '0;
      label_q    <= 1'b0;
      tok_beg_q  <= '0;
      lne_q      <= '0;
      quote_q    <= 1'b0;
      bslash_q   <= 1'b0;
      pcnt_q     <= '0;
      nonempty_q <= 1'b0;
      dir_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      label_q    <= label_d;
      tok_beg_q  <= tok_beg_d;
      lne_q      <= lne_d;
      quote_q    <= quote_d;
      bslash_q   <= bslash_d;
      pcnt_q     <= pcnt_d;
      nonempty_q <= nonempty_d;
      dir_q      <= dir_d;
    end
  end

  alt_res_fifo u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (fctl),
    .wr0_i     (res0),
    .wr1_i     (res1),
    .rd_data_o (rd_data),
    .valid_o   (fifo_valid),
    .room_o    (room)
  );

  assign out_o.valid        = fifo_valid;
  assign out_o.token_kind   = rd_data.token_kind;
  assign out_o.is_directive = rd_data.is_directive;
  assign out_o.start_pos    = rd_data.start_pos;
  assign out_o.end_pos      = rd_data.end_pos;
  assign out_o.param_index  = rd_data.param_index;
  assign out_o.error_code   = rd_data.error_code;
  assign out_o.last         = rd_data.last;

endmodule
